// File: design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TGPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define TGPS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/tgps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgps_pkg
// types and constants shared by the tone generator controller and datapath
// ----------------------------------------------------------------------------
package tgps_pkg;

  localparam int ClockW      = 26;
  localparam int PeriodW     = 16;
  localparam int ToneW       = 12;
  localparam int UnitsW      = 8;
  localparam int StepW       = 8;
  localparam int CfgDataW    = 32;
  localparam int CfgAddrW    = 3;

  localparam logic [ClockW-1:0]  ClockHzReset = 26'd11059200;
  localparam logic [PeriodW-1:0] PeriodReset  = 16'd64000;

  // prescale 8 times two half periods: divide clock by 16 as a shift
  localparam int PrescaleShift = 4;
  localparam int DvdW          = ClockW - PrescaleShift;
  localparam int DivSteps      = DvdW;
  localparam int DivCntW       = $clog2(DivSteps);

  // budget = product / 40 = (product >> 3) / 5, the divide by 5 by reciprocal
  localparam int ProdW         = UnitsW + ToneW;
  localparam int BudgetShift   = 3;
  localparam int ScaledW       = ProdW - BudgetShift;
  localparam int Recip5Shift   = 18;
  localparam int RecipW        = 16;
  localparam logic [RecipW-1:0] Recip5 = 16'd52429;
  localparam int MulW          = ScaledW + RecipW;

  localparam logic [CfgAddrW-1:0] RegClockHz = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } tgps_state_t;

  typedef struct packed {
    logic tick;
    logic reject;
    logic start;
    logic step;
    logic commit;
  } tgps_cmd_t;

  typedef struct packed {
    logic tone_zero;
    logic div_last;
  } tgps_status_t;

endpackage

// File: design/tgps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgps_ctrl
// request sequencing: accepts requests, runs the divide sequence for play
// requests with nonzero tone and owns the result valid flag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgps_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_req_type,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  tgps_pkg::tgps_status_t status,
  output tgps_pkg::tgps_cmd_t    cmd
);
  import tgps_pkg::*;

  tgps_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;
  logic        out_load;

  // the result register must be empty or draining before a new request
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type && !status.tone_zero) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.tick   = accept && !in_req_type;
        cmd.reject = accept && in_req_type && status.tone_zero;
        cmd.start  = accept && in_req_type && !status.tone_zero;
      end
      ST_DIV:  cmd.step   = 1'b1;
      ST_LOAD: cmd.commit = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign out_load = cmd.tick || cmd.reject || cmd.commit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TGPS_NEVER(a_commit_into_full, cmd.commit && out_valid_r, "result overwritten")
  `TGPS_ASSERT(a_start_divides, cmd.start |=> state_r == ST_DIV, "divide not started")
  `TGPS_ASSERT(a_load_presents, state_r == ST_LOAD |=> out_valid_r, "play result not presented")

endmodule

// File: design/tgps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgps_dp
// tone state, tick update, bit-serial period divider and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgps_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tgps_pkg::tgps_cmd_t                  cmd,
  output tgps_pkg::tgps_status_t               status,
  input  logic [tgps_pkg::ClockW-1:0]         clock_hz,
  input  logic [tgps_pkg::UnitsW-1:0]         in_duration_units,
  input  logic [tgps_pkg::ToneW-1:0]          in_tone_hz,
  input  logic signed [tgps_pkg::StepW-1:0]   in_sweep_delta,
  output logic                                out_pin_level,
  output logic                                out_playing,
  output logic                                out_rejected
);
  import tgps_pkg::*;

  // architectural tone state
  logic [PeriodW-1:0] half_period_r, half_period_nxt;
  logic [PeriodW-1:0] tick_count_r,  tick_count_nxt;
  logic [PeriodW-1:0] budget_r,      budget_nxt;
  logic [StepW-1:0]   sweep_r,       sweep_nxt;
  logic               level_r,       level_nxt;
  logic               enabled_r,     enabled_nxt;

  // divider and play operands
  logic [DvdW-1:0]    quo_r,     quo_nxt;
  logic [ToneW-1:0]   rem_r,     rem_nxt;
  logic [ToneW-1:0]   divisor_r, divisor_nxt;
  logic [DivCntW-1:0] cnt_r,     cnt_nxt;
  logic [ProdW-1:0]   prod_r,    prod_nxt;
  logic [StepW-1:0]   step_hold_r, step_hold_nxt;

  // result register
  logic out_pin_r, out_pin_nxt;
  logic out_playing_r, out_playing_nxt;
  logic out_rejected_r, out_rejected_nxt;

  logic               match;
  logic [ToneW:0]     rem_sh;
  logic               ge;
  logic [MulW-1:0]    scaled;
  logic [PeriodW-1:0] period_new;
  logic [PeriodW-1:0] budget_new;

  assign status.tone_zero = (in_tone_hz == '0);
  assign status.div_last  = (cnt_r == DivCntW'(DivSteps - 1));

  assign match  = (tick_count_r == half_period_r);
  assign rem_sh = {rem_r, quo_r[DvdW-1]};
  assign ge     = (rem_sh >= {1'b0, divisor_r});
  assign scaled = MulW'(prod_r[ProdW-1:BudgetShift]) * MulW'(Recip5);
  assign budget_new = PeriodW'(scaled[MulW-1:Recip5Shift]);
  assign period_new = (quo_r[DvdW-1:PeriodW] != '0) ? {PeriodW{1'b1}} : quo_r[PeriodW-1:0];

  always_comb begin
    half_period_nxt = half_period_r;
    tick_count_nxt  = tick_count_r;
    budget_nxt      = budget_r;
    sweep_nxt       = sweep_r;
    level_nxt       = level_r;
    enabled_nxt     = enabled_r;
    if (cmd.tick) begin
      if (!match) begin
        tick_count_nxt = tick_count_r + PeriodW'(1);
      end else begin
        tick_count_nxt = '0;
        if (enabled_r) begin
          level_nxt = !level_r;
          // every fourth toggle the period moves by the sweep step
          if (budget_r[1:0] == 2'b11) begin
            half_period_nxt = half_period_r - {{(PeriodW-StepW){sweep_r[StepW-1]}}, sweep_r};
          end
          if (budget_r == '0) begin
            enabled_nxt = 1'b0;
            level_nxt   = 1'b0;
          end else begin
            budget_nxt = budget_r - PeriodW'(1);
          end
        end
      end
    end else if (cmd.commit) begin
      half_period_nxt = period_new;
      budget_nxt      = budget_new;
      sweep_nxt       = step_hold_r;
      enabled_nxt     = 1'b1;
    end
  end

  always_comb begin
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    divisor_nxt   = divisor_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    step_hold_nxt = step_hold_r;
    if (cmd.start) begin
      quo_nxt       = clock_hz[ClockW-1:PrescaleShift];
      rem_nxt       = '0;
      divisor_nxt   = in_tone_hz;
      cnt_nxt       = '0;
      prod_nxt      = ProdW'(in_duration_units) * ProdW'(in_tone_hz);
      step_hold_nxt = in_sweep_delta;
    end else if (cmd.step) begin
      quo_nxt = {quo_r[DvdW-2:0], ge};
      rem_nxt = ge ? ToneW'(rem_sh - {1'b0, divisor_r}) : rem_sh[ToneW-1:0];
      cnt_nxt = cnt_r + DivCntW'(1);
    end
  end

  always_comb begin
    out_pin_nxt      = out_pin_r;
    out_playing_nxt  = out_playing_r;
    out_rejected_nxt = out_rejected_r;
    if (cmd.tick || cmd.commit) begin
      out_pin_nxt      = level_nxt;
      out_playing_nxt  = enabled_nxt;
      out_rejected_nxt = 1'b0;
    end else if (cmd.reject) begin
      out_pin_nxt      = level_r;
      out_playing_nxt  = enabled_r;
      out_rejected_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= PeriodReset;
      tick_count_r  <= '0;
      budget_r      <= '0;
      sweep_r       <= '0;
      level_r       <= 1'b0;
      enabled_r     <= 1'b0;
    end else begin
      half_period_r <= half_period_nxt;
      tick_count_r  <= tick_count_nxt;
      budget_r      <= budget_nxt;
      sweep_r       <= sweep_nxt;
      level_r       <= level_nxt;
      enabled_r     <= enabled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r          <= quo_nxt;
    rem_r          <= rem_nxt;
    divisor_r      <= divisor_nxt;
    cnt_r          <= cnt_nxt;
    prod_r         <= prod_nxt;
    step_hold_r    <= step_hold_nxt;
    out_pin_r      <= out_pin_nxt;
    out_playing_r  <= out_playing_nxt;
    out_rejected_r <= out_rejected_nxt;
  end

  assign out_pin_level = out_pin_r;
  assign out_playing   = out_playing_r;
  assign out_rejected  = out_rejected_r;

  `TGPS_ASSERT(a_period_quiet, !(cmd.tick || cmd.commit) |=> $stable(half_period_r), "period moved")
  `TGPS_ASSERT(a_idle_pin_low, !enabled_r && $past(enabled_r) |-> !level_r, "pin high after effect")

endmodule

// File: design/tone_generator_with_pitch_sweep_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_generator_with_pitch_sweep_core
// square-wave sound effect generator with per-toggle pitch sweep
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one request per prescaled timer tick
//   (in_req_type 0) or a play request (in_req_type 1) with length, tone and
//   sweep step. every request gives exactly one result on the out_ channel
//   (out_valid / out_stall): pin level, playing flag and a rejected flag for
//   a play request with zero tone.
//   a tick or a rejected play request needs no divide: its result appears in
//   the output register the cycle after acceptance, and ticks can follow at
//   one per cycle while results are taken.
//   a valid play request divides the prescaled clock (clock_hz / 16) by
//   the tone bit-serially, one quotient bit per cycle for 22 quotient bits,
//   then a load state registers its result; in_stall is high meanwhile.
//   while a result waits under out_stall, in_stall is raised; a result taken
//   in the same cycle frees the register for the next request.
//   the clock frequency register sits at apb address 0; write it only idle.
//   reset restores clock_hz to 11059200, period 64000, tone level low, tone off.
// ----------------------------------------------------------------------------
module tone_generator_with_pitch_sweep_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [tgps_pkg::UnitsW-1:0]         in_duration_units,
  input  logic [tgps_pkg::ToneW-1:0]          in_tone_hz,
  input  logic signed [tgps_pkg::StepW-1:0]   in_sweep_delta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pin_level,
  output logic                                out_playing,
  output logic                                out_rejected,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tgps_pkg::CfgAddrW-1:0]       paddr,
  input  logic [tgps_pkg::CfgDataW-1:0]       pwdata,
  output logic [tgps_pkg::CfgDataW-1:0]       prdata,
  output logic                                pready
);
  import tgps_pkg::*;

  logic [ClockW-1:0] clock_hz_r, clock_hz_nxt;
  logic              cfg_hit;
  tgps_cmd_t         cmd;
  tgps_status_t      status;

  // word select only, byte offset bits are ignored
  assign cfg_hit = (paddr[CfgAddrW-1:2] == RegClockHz[CfgAddrW-1:2]);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? CfgDataW'(clock_hz_r) : '0;

  always_comb begin
    clock_hz_nxt = clock_hz_r;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      clock_hz_nxt = pwdata[ClockW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= ClockHzReset;
    end else begin
      clock_hz_r <= clock_hz_nxt;
    end
  end

  tgps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  tgps_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .clock_hz          (clock_hz_r),
    .in_duration_units (in_duration_units),
    .in_tone_hz        (in_tone_hz),
    .in_sweep_delta    (in_sweep_delta),
    .out_pin_level     (out_pin_level),
    .out_playing       (out_playing),
    .out_rejected      (out_rejected)
  );

endmodule
